// ===== sv/sbda_pkg.sv =====
package sbda_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // decimal digits of the largest magnitude
    localparam int DIGITS    = 10;
    localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);
    localparam int STEP_W      = $clog2(VALUE_W);

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    // command to every digit cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_ROTATE
    } cell_cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/sbda_if.sv =====
// number request channel
interface sbda_num_if;
    logic                                valid;
    logic                                ready;
    logic signed [sbda_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// character request channel
interface sbda_char_if;
    logic                        valid;
    logic                        ready;
    logic [sbda_pkg::CHAR_W-1:0] char_code;
    logic                        last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== sv/sbda_cell.sv =====
// one bcd digit of the double-dabble chain
module sbda_cell
(
    input  logic                            clk,
    input  sbda_pkg::cell_cmd_t             cmd,
    input  logic                            bit_in,
    output logic                            bit_out,
    input  logic [sbda_pkg::DIGIT_W-1:0]    digit_in,
    output logic [sbda_pkg::DIGIT_W-1:0]    digit_out
);

    logic [sbda_pkg::DIGIT_W-1:0] digit_reg;
    logic [sbda_pkg::DIGIT_W-1:0] digit_next;
    logic [sbda_pkg::DIGIT_W-1:0] adj;

    // add three when the digit would overflow after doubling
    assign adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;

    assign bit_out   = adj[sbda_pkg::DIGIT_W-1];
    assign digit_out = digit_reg;

    always_comb
    begin
        unique case (cmd)
            sbda_pkg::CELL_HOLD:   digit_next = digit_reg;
            sbda_pkg::CELL_CLEAR:  digit_next = '0;
            sbda_pkg::CELL_DABBLE: digit_next = {adj[sbda_pkg::DIGIT_W-2:0], bit_in};
            sbda_pkg::CELL_ROTATE: digit_next = digit_in;
            default:               digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== sv/sbda_chain.sv =====
// row of digit cells, least significant digit at index zero
module sbda_chain
(
    input  logic                            clk,
    input  sbda_pkg::cell_cmd_t             cmd,
    input  logic                            bit_in,
    output logic [sbda_pkg::DIGIT_W-1:0]    top_digit
);

    logic [sbda_pkg::DIGITS:0]                      carry;
    logic [sbda_pkg::DIGITS:0][sbda_pkg::DIGIT_W-1:0] dig;

    assign carry[0] = bit_in;
    assign dig[0]   = '0;

    // cell i takes its shift bit and its digit from cell i-1
    for (genvar i = 0; i < sbda_pkg::DIGITS; i++)
    begin : g_cell
        sbda_cell u_cell
        (
            .clk       (clk),
            .cmd       (cmd),
            .bit_in    (carry[i]),
            .bit_out   (carry[i+1]),
            .digit_in  (dig[i]),
            .digit_out (dig[i+1])
        );
    end

    assign top_digit = dig[sbda_pkg::DIGITS];

endmodule

// ===== sv/signed_binary_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to decimal ASCII text.
// num channel: one request carries a signed 32-bit value. The block takes
// a request only when idle, one number at a time.
// text channel: one request per character, most significant digit first,
// preceded by '-' for a negative value; last marks the final character.
// Zero gives the single character '0'; leading zeros are never sent.
// Sequence: double-dabble shifting of the magnitude through the row of ten
// digit cells, then a skip step that drops leading zeros by rotating the
// row but keeps at least one digit, then the characters one at a time into
// the output register, each when the register is free. A sign goes first,
// before the digits. The next number is taken in the cycle after the last
// character is loaded into the output register.
// The output register holds a character until it is taken; while the
// receiver stalls, the sign and emit steps wait and the cells hold their digits.
// Reset empties the output register and returns the sequencer to idle.
module signed_binary_to_decimal_ascii_core
(
    input  logic        clk,
    input  logic        rst_n,
    sbda_num_if.sink    num,
    sbda_char_if.source text
);

    sbda_pkg::state_t                   state_reg;
    sbda_pkg::state_t                   state_next;
    logic [sbda_pkg::VALUE_W-1:0]       mag_reg;
    logic [sbda_pkg::VALUE_W-1:0]       mag_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic [sbda_pkg::STEP_W-1:0]        step_reg;
    logic [sbda_pkg::STEP_W-1:0]        step_next;
    logic [sbda_pkg::DIGIT_CNT_W-1:0]   cnt_reg;
    logic [sbda_pkg::DIGIT_CNT_W-1:0]   cnt_next;
    logic                               ovalid_reg;
    logic                               ovalid_next;
    logic [sbda_pkg::CHAR_W-1:0]        char_reg;
    logic [sbda_pkg::CHAR_W-1:0]        char_next;
    logic                               last_reg;
    logic                               last_next;

    sbda_pkg::cell_cmd_t                cmd;
    logic [sbda_pkg::DIGIT_W-1:0]       top_digit;
    logic                               accept;
    logic                               slot_free;
    logic                               top_zero;
    logic                               cnt_one;
    logic [sbda_pkg::VALUE_W-1:0]       raw;

    assign raw       = num.value;
    assign accept    = num.valid && num.ready;
    assign slot_free = !ovalid_reg || text.ready;
    assign top_zero  = (top_digit == '0);
    assign cnt_one   = (cnt_reg == sbda_pkg::DIGIT_CNT_W'(1));

    assign num.ready      = (state_reg == sbda_pkg::ST_IDLE);
    assign text.valid     = ovalid_reg;
    assign text.char_code = char_reg;
    assign text.last      = last_reg;

    // digit cells
    sbda_chain u_chain
    (
        .clk       (clk),
        .cmd       (cmd),
        .bit_in    (mag_reg[sbda_pkg::VALUE_W-1]),
        .top_digit (top_digit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (num.valid)
                    state_next = sbda_pkg::ST_CONVERT;
            end
            sbda_pkg::ST_CONVERT:
            begin
                if (step_reg == sbda_pkg::STEP_W'(sbda_pkg::VALUE_W - 1))
                    state_next = sbda_pkg::ST_SKIP;
            end
            sbda_pkg::ST_SKIP:
            begin
                if (!(top_zero && !cnt_one))
                    state_next = neg_reg ? sbda_pkg::ST_SIGN : sbda_pkg::ST_EMIT;
            end
            sbda_pkg::ST_SIGN:
            begin
                if (slot_free)
                    state_next = sbda_pkg::ST_EMIT;
            end
            sbda_pkg::ST_EMIT:
            begin
                if (slot_free && cnt_one)
                    state_next = sbda_pkg::ST_IDLE;
            end
            default: state_next = sbda_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd         = sbda_pkg::CELL_HOLD;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !text.ready;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd       = sbda_pkg::CELL_CLEAR;
                    neg_next  = raw[sbda_pkg::VALUE_W-1];
                    mag_next  = raw[sbda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
                    step_next = '0;
                end
            end
            sbda_pkg::ST_CONVERT:
            begin
                cmd       = sbda_pkg::CELL_DABBLE;
                mag_next  = {mag_reg[sbda_pkg::VALUE_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                cnt_next  = sbda_pkg::DIGIT_CNT_W'(sbda_pkg::DIGITS);
            end
            sbda_pkg::ST_SKIP:
            begin
                // drop a leading zero, keep at least one digit
                if (top_zero && !cnt_one)
                begin
                    cmd      = sbda_pkg::CELL_ROTATE;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            sbda_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    char_next   = sbda_pkg::CHAR_MINUS;
                    last_next   = 1'b0;
                end
            end
            sbda_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd         = sbda_pkg::CELL_ROTATE;
                    cnt_next    = cnt_reg - 1'b1;
                    ovalid_next = 1'b1;
                    char_next   = sbda_pkg::CHAR_ZERO
                                + {{(sbda_pkg::CHAR_W - sbda_pkg::DIGIT_W){1'b0}}, top_digit};
                    last_next   = cnt_one;
                end
            end
            default: cmd = sbda_pkg::CELL_HOLD;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sbda_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        cnt_reg  <= cnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import sbda_pkg::*;

    localparam int RADIX        = 10;
    localparam int IDLE_PCT     = 23;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 300;
    localparam int SETTLE_CYC   = 60;

    // one character as the text channel carries it
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // one pending number request, optionally held until the text drains
    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 hold_off;
    } num_req_t;

    logic clk;
    logic rst_n;

    sbda_num_if  num_ch();
    sbda_char_if text_ch();

    num_req_t   num_req_q[$];
    text_char_t text_expect_q[$];
    int         err_cnt;
    int         taken_cnt;
    bit         num_fire;
    bit         calm;

    signed_binary_to_decimal_ascii_core u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_ch),
        .text  (text_ch)
    );

    // decimal text of one number, sign first, no leading zeros
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digs[$];
        text_char_t         ch;
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        if (mag == '0)
        begin
            ch.code = CHAR_ZERO;
            ch.last = 1'b1;
            text_expect_q.push_back(ch);
            return;
        end
        while (mag != '0)
        begin
            digs.push_front(DIGIT_W'(mag % RADIX));
            mag = mag / RADIX;
        end
        if (v[VALUE_W-1])
        begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            text_expect_q.push_back(ch);
        end
        foreach (digs[i])
        begin
            ch.code = CHAR_ZERO + CHAR_W'(digs[i]);
            ch.last = (i == digs.size() - 1);
            text_expect_q.push_back(ch);
        end
    endfunction

    // random value, mostly spread evenly over digit counts
    function automatic logic [VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     nd;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        nd = $urandom_range(1, DIGITS);
        lo = 1;
        repeat (nd - 1) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (nd == 1)
            lo = 0;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        if ($urandom_range(0, 1) == 1)
            mag = -mag;
        return VALUE_W'(mag);
    endfunction

    function automatic void add_request(input logic [VALUE_W-1:0] v, input bit hold);
        num_req_t req;
        req.value    = v;
        req.hold_off = hold;
        num_req_q.push_back(req);
    endfunction

    // clock, reset and known input levels
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        num_ch.valid   = 1'b0;
        num_ch.value   = '0;
        text_ch.ready  = 1'b0;
        fork
            forever #6 clk = ~clk;
            begin
                repeat (5) @(negedge clk);
                rst_n <= 1'b1;
            end
        join
    end

    assign calm = (taken_cnt >= CALM_FIRST) && (taken_cnt < CALM_LAST);

    // request driver, inputs change on the falling edge
    always @(negedge clk)
    begin : drive_proc
        num_req_t req;
        if (rst_n)
        begin
            if (!num_ch.valid || num_fire)
            begin
                if (num_req_q.size() != 0
                    && !(num_req_q[0].hold_off && text_expect_q.size() != 0)
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req = num_req_q.pop_front();
                    num_ch.valid <= 1'b1;
                    num_ch.value <= req.value;
                end
                else
                begin
                    num_ch.valid <= 1'b0;
                end
            end
            text_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor, both channels sampled on the rising edge
    always @(posedge clk)
    begin : watch_proc
        text_char_t got;
        text_char_t want;
        num_fire = 1'b0;
        if (rst_n)
        begin
            if (num_ch.valid && num_ch.ready)
            begin
                predict_text(num_ch.value);
                taken_cnt++;
                num_fire = 1'b1;
            end
            if (text_ch.valid && text_ch.ready)
            begin
                got.code = text_ch.char_code;
                got.last = text_ch.last;
                if (text_expect_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected char: code %0d last %0d", got.code, got.last);
                end
                else
                begin
                    want = text_expect_q.pop_front();
                    if (got != want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("char mismatch: expected code %0d last %0d, got code %0d last %0d",
                                     want.code, want.last, got.code, got.last);
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        err_cnt   = 0;
        taken_cnt = 0;

        // directed: zero, sign edges, digit count edges, bit patterns
        add_request(32'd0, 1'b0);
        add_request(32'd1, 1'b0);
        add_request(-32'sd1, 1'b0);
        add_request(32'd9, 1'b0);
        add_request(32'd10, 1'b0);
        add_request(-32'sd10, 1'b0);
        add_request(32'd99, 1'b0);
        add_request(32'd100, 1'b0);
        add_request(-32'sd7, 1'b0);
        add_request(32'h7FFF_FFFF, 1'b0);
        add_request(32'h8000_0000, 1'b0);
        add_request(32'h8000_0001, 1'b0);
        add_request(32'd1000000000, 1'b0);
        add_request(32'd999999999, 1'b0);
        add_request(-32'sd999999999, 1'b0);
        add_request(32'd1234567890, 1'b0);
        add_request(-32'sd1234567890, 1'b0);
        add_request(32'h5555_5555, 1'b0);
        add_request(32'hAAAA_AAAA, 1'b0);
        add_request(32'd100000, 1'b0);

        // random numbers, with a few points where the sender drains first
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_request(random_value(), (i == 0) || (i == 150) || (i == 350));

        wait (rst_n);
        wait (num_req_q.size() == 0 && !num_ch.valid);
        wait (text_expect_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);

        if (err_cnt == 0 && text_expect_q.size() == 0)
            $display("PASS signed_binary_to_decimal_ascii_core");
        else
            $display("FAIL signed_binary_to_decimal_ascii_core");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL signed_binary_to_decimal_ascii_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sbda_pkg.sv
sv/sbda_if.sv
sv/sbda_cell.sv
sv/sbda_chain.sv
sv/signed_binary_to_decimal_ascii_core.sv
bench/testbench.sv
